// ----- src/kss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_pkg
// Shared types, constants and helpers of the KMP substring search unit.
// ----------------------------------------------------------------------------
package kss_pkg;

  localparam int unsigned PATTERN_MAX_DEF   = 16;
  localparam int unsigned POSITION_BITS_DEF = 16;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned LEN_W      = 5;
  localparam int unsigned START_W    = 16;
  localparam int unsigned PAT_W      = 128;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_ADDR_W = 5;

  // register indexes (paddr[4:3])
  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;

  typedef enum logic {
    KSS_RUN,
    KSS_REPLAY
  } kss_state_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } kss_cell_ctrl_t;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [LEN_W-1:0] pat_len;
    logic             wr;
  } kss_cfg_t;

  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                  input logic [3:0] idx);
    return pat[idx*BYTE_W +: BYTE_W];
  endfunction

  function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] raw,
                                                 input logic [LEN_W-1:0] pmax);
    logic [LEN_W-1:0] len;
    len = raw;
    if (raw == '0) begin
      len = LEN_W'(1);
    end else if (raw > pmax) begin
      len = pmax;
    end
    return len;
  endfunction

endpackage

// ----- src/kss_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_in_if
// Text byte channel: valid/ready with byte and end-of-text marker.
// ----------------------------------------------------------------------------
interface kss_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_end;

  modport source (output valid, output text_byte, output text_end, input ready);
  modport sink   (input valid, input text_byte, input text_end, output ready);
endinterface

// ----- src/kss_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_out_if
// Result channel: valid/ready with match flags and first match start.
// ----------------------------------------------------------------------------
interface kss_out_if;
  logic        valid;
  logic        ready;
  logic        match_here;
  logic        found;
  logic [15:0] first_start;
  logic        final_result;
  logic        too_long;

  modport source (output valid, output match_here, output found, output first_start,
                  output final_result, output too_long, input ready);
  modport sink   (input valid, input match_here, input found, input first_start,
                  input final_result, input too_long, output ready);
endinterface

// ----- src/kss_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_cfg
// APB register file: pattern bytes and pattern length.
// ----------------------------------------------------------------------------
module kss_cfg import kss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output kss_cfg_t              cfg_o
);

  logic [CFG_DATA_W-1:0] pat_low_q;
  logic [CFG_DATA_W-1:0] pat_high_q;
  logic [LEN_W-1:0]      pat_len_q;
  logic                  wr;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr      = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LEN_W'(1);
    end else if (wr) begin
      case (reg_idx)
        REG_PAT_LOW:  pat_low_q  <= pwdata;
        REG_PAT_HIGH: pat_high_q <= pwdata;
        REG_PAT_LEN:  pat_len_q  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PAT_LOW:  prdata = pat_low_q;
      REG_PAT_HIGH: prdata = pat_high_q;
      REG_PAT_LEN:  prdata = CFG_DATA_W'(pat_len_q);
      default:      prdata = '0;
    endcase
  end

  // any write, even outside the map, forces a state replay
  assign cfg_o.pattern = {pat_high_q, pat_low_q};
  assign cfg_o.pat_len = pat_len_q;
  assign cfg_o.wr      = wr;

endmodule

// ----- src/kss_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_cell
// One prefix-length cell: flags that the text suffix matches the pattern
// prefix ending at this cell's byte, fed by its left neighbor.
// ----------------------------------------------------------------------------
module kss_cell import kss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kss_cell_ctrl_t    ctrl_i,
  input  logic              enable_i,
  input  logic              prev_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic [BYTE_W-1:0] pat_i,
  output logic              next_o,
  output logic              act_o
);

  logic act_q;
  logic act_d;

  assign next_o = enable_i & prev_i & (byte_i == pat_i);

  always_comb begin
    act_d = act_q;
    if (ctrl_i.clear) begin
      act_d = 1'b0;
    end else if (ctrl_i.shift) begin
      act_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else begin
      act_q <= act_d;
    end
  end

  assign act_o = act_q;

endmodule

// ----- src/kmp_substring_search_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmp_substring_search_unit
// Streaming KMP pattern search over a chain of prefix cells.
// ----------------------------------------------------------------------------
// The result is registered on the input transfer, shown in the next cycle.
// Throughput: one text byte per cycle unless replay or output stalls it; the
//   cell chain advances once per byte. A config write holds off input while
//   pattern[0..q-1] (q = matched prefix, at most PATTERN_MAX-1) is replayed.
// Reset (async, active low): pattern 0, length 1, all per-text state cleared.
module kmp_substring_search_unit import kss_pkg::*; #(
  parameter int unsigned PATTERN_MAX   = PATTERN_MAX_DEF,
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  kss_in_if.sink                in_if,
  kss_out_if.source             out_if,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned CNT_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  kss_cfg_t       cfg;
  kss_cell_ctrl_t cell_ctrl;
  kss_state_e     state_q, state_d;

  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [LEN_W-1:0]         q_q;
  logic [LEN_W-1:0]         len_used;
  logic [LEN_W-1:0]         q_eff;
  logic [LEN_W-1:0]         q_next;
  logic                     replay_shift;
  logic                     in_fire;
  logic [BYTE_W-1:0]        chain_byte;
  logic [PATTERN_MAX-1:0]   act;
  logic [PATTERN_MAX-1:0]   nxt;
  logic                     hit;

  logic [POSITION_BITS-1:0] pos_q;
  logic                     found_q;
  logic [START_W-1:0]       fms_q;
  logic                     sat_q;

  logic                     found_new;
  logic [START_W-1:0]       fms_new;
  logic                     sat_new;

  logic                     out_valid_q;
  logic                     match_q, found_o_q, final_q, too_long_q;
  logic [START_W-1:0]       start_q;

  kss_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign len_used = used_len(cfg.pat_len, LEN_W'(PATTERN_MAX));
  assign q_eff    = (q_q >= len_used) ? '0 : q_q;

  assign in_if.ready = (state_q == KSS_RUN) && (!out_valid_q || out_if.ready);
  assign in_fire     = in_if.valid && in_if.ready;

  // ---- replay sequencer --------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= KSS_RUN;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    replay_shift = 1'b0;
    if (cfg.wr) begin
      state_d = KSS_REPLAY;
      cnt_d   = '0;
    end else begin
      case (state_q)
        KSS_REPLAY: begin
          if (LEN_W'(cnt_q) == q_eff) begin
            state_d = KSS_RUN;
          end else begin
            replay_shift = 1'b1;
            cnt_d        = cnt_q + CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // replay feeds pattern[0..q-1] to rebuild the cell flags for the new pattern
  assign chain_byte = (state_q == KSS_REPLAY) ? pat_byte(cfg.pattern, 4'(cnt_q))
                                              : in_if.text_byte;

  assign cell_ctrl.shift = in_fire | replay_shift;
  assign cell_ctrl.clear = cfg.wr | (in_fire & in_if.text_end);

  // ---- cell chain: cell g tracks prefix length g+1 -----------------------
  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    logic prev;
    if (g == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = act[g-1];
    end

    kss_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .enable_i (LEN_W'(g + 1) <= len_used),
      .prev_i   (prev),
      .byte_i   (chain_byte),
      .pat_i    (pat_byte(cfg.pattern, 4'(g))),
      .next_o   (nxt[g]),
      .act_o    (act[g])
    );
  end

  // full match, and the longest proper prefix still alive (KMP state)
  always_comb begin
    hit    = 1'b0;
    q_next = '0;
    for (int unsigned g = 0; g < PATTERN_MAX; g++) begin
      if (LEN_W'(g + 1) == len_used) begin
        hit = hit | nxt[g];
      end
      if ((LEN_W'(g + 1) < len_used) && nxt[g]) begin
        q_next = LEN_W'(g + 1);
      end
    end
  end

  // ---- per-text state ----------------------------------------------------
  always_comb begin
    found_new = found_q;
    fms_new   = fms_q;
    if (hit && !found_q) begin
      found_new = 1'b1;
      fms_new   = START_W'(pos_q) - START_W'(len_used - LEN_W'(1));
    end
    sat_new = sat_q | (pos_q == POS_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q     <= '0;
      pos_q   <= '0;
      found_q <= 1'b0;
      fms_q   <= '0;
      sat_q   <= 1'b0;
    end else if (in_fire) begin
      if (in_if.text_end) begin
        q_q     <= '0;
        pos_q   <= '0;
        found_q <= 1'b0;
        fms_q   <= '0;
        sat_q   <= 1'b0;
      end else begin
        q_q     <= q_next;
        pos_q   <= (pos_q == POS_MAX) ? pos_q : pos_q + POSITION_BITS'(1);
        found_q <= found_new;
        fms_q   <= fms_new;
        sat_q   <= sat_new;
      end
    end
  end

  // ---- output register ---------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      match_q    <= hit;
      found_o_q  <= found_new;
      start_q    <= found_new ? fms_new : '0;
      final_q    <= in_if.text_end;
      too_long_q <= sat_new;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.match_here   = match_q;
  assign out_if.found        = found_o_q;
  assign out_if.first_start  = start_q;
  assign out_if.final_result = final_q;
  assign out_if.too_long     = too_long_q;

endmodule

// ----- src/kss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kss_checker
// Port-level checks of the KMP search unit, bound to the top level.
// ----------------------------------------------------------------------------
module kss_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        match_here,
  input logic        found,
  input logic [15:0] first_start,
  input logic        final_result,
  input logic        too_long,
  input logic        psel,
  input logic        penable,
  input logic        pwrite
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(match_here) && $stable(found)
      && $stable(first_start) && $stable(final_result) && $stable(too_long))
    else $error("stalled result changed");

  a_match_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && match_here |-> found)
    else $error("match without found");

  a_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !found |-> first_start == 16'd0)
    else $error("first_start set without a match");

  // a register write starts a replay, so input is held off next cycle
  a_cfg_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite |=> !in_ready)
    else $error("input taken during replay");

endmodule

bind kmp_substring_search_unit kss_checker u_kss_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .match_here   (out_if.match_here),
  .found        (out_if.found),
  .first_start  (out_if.first_start),
  .final_result (out_if.final_result),
  .too_long     (out_if.too_long),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite)
);
